### src/sei_pkg.sv
// Shared constants and types for the segment and edge intersection block.
package sei_pkg;

  localparam int unsigned COORD_WIDTH_DEF     = 16;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 16;

  // The unit normal is reported in Q2.14.
  localparam int unsigned NORM_WIDTH     = 16;
  localparam int unsigned NORM_FRAC_BITS = 14;
  // The squared normal ratio is resolved to two more bits than needed, so
  // that its root carries one extra bit for round to nearest.
  localparam int unsigned NORM_QUO_BITS  = 2 * NORM_FRAC_BITS + 3;
  localparam int unsigned NORM_ROOT_BITS = (NORM_QUO_BITS + 1) / 2;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### src/sei_fifo.sv
// Small register queue between the classifying front and the arithmetic back.
module sei_fifo import sei_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output queue_status_t    status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W:0]   wr_q, rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q[PTR_W-1:0]] <= data_i;
  end

  assign data_o         = mem_q[rd_q[PTR_W-1:0]];
  assign status_o.empty = (wr_q == rd_q);
  assign status_o.full  = (wr_q[PTR_W] != rd_q[PTR_W]) &&
                          (wr_q[PTR_W-1:0] == rd_q[PTR_W-1:0]);

endmodule

### src/sei_div.sv
// Pipelined restoring divider, one quotient bit per stage, for num <= den.
module sei_div #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned QUO_W  = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DATA_W-1:0] num_i,
  input  logic [DATA_W-1:0] den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  // Quotient is floor(num * 2^(QUO_W-1) / den).
  logic              valid_q [QUO_W];
  logic [DATA_W-1:0] rem_q   [QUO_W];
  logic [DATA_W-1:0] den_q   [QUO_W];
  logic [QUO_W-1:0]  quo_q   [QUO_W];
  logic [SIDE_W-1:0] side_q  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    if (i == 0) begin : g_first
      logic take;
      assign take = (num_i >= den_i);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[i] <= 1'b0;
        end else if (en_i) begin
          valid_q[i] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[i]  <= QUO_W'(take);
          rem_q[i]  <= take ? (num_i - den_i) : num_i;
          den_q[i]  <= den_i;
          side_q[i] <= side_i;
        end
      end
    end else begin : g_step
      logic [DATA_W:0] shifted;
      logic            take;
      assign shifted = {rem_q[i-1], 1'b0};
      assign take    = (shifted >= {1'b0, den_q[i-1]});
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[i] <= 1'b0;
        end else if (en_i) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[i]  <= {quo_q[i-1][QUO_W-2:0], take};
          rem_q[i]  <= take ? DATA_W'(shifted - {1'b0, den_q[i-1]}) : DATA_W'(shifted);
          den_q[i]  <= den_q[i-1];
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

### src/sei_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module sei_sqrt #(
  parameter int unsigned IN_W   = 8,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned ROOT_W = (IN_W + 1) / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned PAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 3;

  logic              valid_q [ROOT_W];
  logic [REM_W-1:0]  rem_q   [ROOT_W];
  logic [ROOT_W-1:0] root_q  [ROOT_W];
  logic [PAD_W-1:0]  rad_q   [ROOT_W];
  logic [SIDE_W-1:0] side_q  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              valid_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [PAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  trial_rem;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (i == 0) begin : g_src
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = PAD_W'(rad_i);
      assign side_in  = side_i;
    end else begin : g_prev
      assign valid_in = valid_q[i-1];
      assign rem_in   = rem_q[i-1];
      assign root_in  = root_q[i-1];
      assign rad_in   = rad_q[i-1];
      assign side_in  = side_q[i-1];
    end

    // Bring down the next pair of radicand bits and try 4*root + 1.
    assign trial_rem = {rem_in[REM_W-3:0], rad_in[PAD_W-1 -: 2]};
    assign trial     = REM_W'({root_in, 2'b01});
    assign take      = (trial_rem >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? (trial_rem - trial) : trial_rem;
        root_q[i] <= {root_in[ROOT_W-2:0], take};
        rad_q[i]  <= rad_in << 2;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

### src/sei_back.sv
// Arithmetic back end: crossing ratio, crossing point, edge check and unit normal.
module sei_back import sei_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
  localparam int unsigned ENTRY_W = 12 * COORD_WIDTH + 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ENTRY_W-1:0]            entry_i,
  input  queue_status_t                 queue_i,
  output logic                          pop_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o,
  output logic signed [NORM_WIDTH-1:0]  unit_normal_x_o,
  output logic signed [NORM_WIDTH-1:0]  unit_normal_y_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned F    = RATIO_FRAC_BITS;
  localparam int unsigned DW   = 2 * W + 3;
  localparam int unsigned SQ_W = 2 * W + 2;
  localparam int unsigned MX_W = F + W + 3;
  localparam int unsigned PT_W = W + 2;
  localparam int unsigned EX_W = W + 3;
  localparam int unsigned PR_W = 2 * W + 4;
  localparam int unsigned DP_W = 2 * W + 5;
  localparam logic signed [MX_W-1:0] RND_HALF = {{(MX_W-1){1'b0}}, 1'b1} << (F - 1);

  typedef struct packed {
    logic                  miss;
    logic [DW-1:0]         un;
    logic [DW-1:0]         ud;
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    logic signed [W-1:0]   ax;
    logic signed [W-1:0]   ay;
    logic signed [W:0]     abx;
    logic signed [W:0]     aby;
    logic signed [W:0]     dx;
    logic signed [W:0]     dy;
  } entry_t;

  typedef struct packed {
    logic                  miss;
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    logic signed [W-1:0]   ax;
    logic signed [W-1:0]   ay;
    logic signed [W:0]     abx;
    logic signed [W:0]     aby;
    logic signed [W:0]     dx;
    logic signed [W:0]     dy;
    logic [DW-1:0]         ll;
    logic [SQ_W-1:0]       sqx;
    logic [SQ_W-1:0]       sqy;
  } geo_t;

  typedef struct packed {
    logic                hit;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic                sgnx;
  } nside_t;

  logic en;
  entry_t entry;

  logic v0_q, v1_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  entry_t e0_q;
  logic signed [SQ_W-1:0] sqx0, sqy0;
  logic [SQ_W-1:0] sqx0_q, sqy0_q;
  geo_t g1_q;
  logic [DW-1:0] un1_q, ud1_q;

  logic       v2;
  logic [F:0] tq2;
  geo_t       g2;

  geo_t g3_q;
  logic signed [MX_W-1:0] mx3_q, my3_q;
  geo_t g4_q;
  logic signed [PT_W-1:0] px4_q, py4_q;
  geo_t g5_q;
  logic signed [PT_W-1:0] px5_q, py5_q;
  logic signed [EX_W-1:0] ex5_q, ey5_q;
  geo_t g6_q;
  logic signed [PT_W-1:0] px6_q, py6_q;
  logic signed [PR_W-1:0] pdx6_q, pdy6_q;

  logic signed [DP_W-1:0] dp6;
  nside_t n7_q;
  logic sgny7_q;
  logic [DW-1:0] ll7_q;
  logic [SQ_W-1:0] sqx7_q, sqy7_q;

  logic                     vd;
  logic [NORM_QUO_BITS-1:0] qx, qy;
  nside_t                   nd;
  logic                     sgny_d;

  logic                      vs;
  logic [NORM_ROOT_BITS-1:0] rx, ry;
  nside_t                    ns;
  logic                      sgny_s;

  logic [NORM_ROOT_BITS:0]     rnd_x, rnd_y;
  logic signed [NORM_WIDTH-1:0] mag_x, mag_y, nrm_x, nrm_y;

  logic                          out_valid_q;
  logic                          hit_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q;
  logic signed [NORM_WIDTH-1:0]  nx_q, ny_q;

  // The whole back end moves as one when the output register can take a result.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !queue_i.empty;
  assign entry = entry_i;

  assign sqx0 = entry.abx * entry.abx;
  assign sqy0 = entry.aby * entry.aby;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= pop_o;
      v1_q        <= v0_q;
      v3_q        <= v2;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= vs;
    end
  end

  assign dp6 = DP_W'(pdx6_q) + DP_W'(pdy6_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q   <= entry;
      sqx0_q <= sqx0;
      sqy0_q <= sqy0;

      g1_q.miss <= e0_q.miss;
      g1_q.x1   <= e0_q.x1;
      g1_q.y1   <= e0_q.y1;
      g1_q.ax   <= e0_q.ax;
      g1_q.ay   <= e0_q.ay;
      g1_q.abx  <= e0_q.abx;
      g1_q.aby  <= e0_q.aby;
      g1_q.dx   <= e0_q.dx;
      g1_q.dy   <= e0_q.dy;
      g1_q.ll   <= DW'(sqx0_q) + DW'(sqy0_q);
      g1_q.sqx  <= sqx0_q;
      g1_q.sqy  <= sqy0_q;
      un1_q     <= e0_q.un;
      ud1_q     <= e0_q.ud;

      // Ratio times the segment direction, with half a Q8.8 step for rounding.
      g3_q  <= g2;
      mx3_q <= $signed({1'b0, tq2}) * g2.dx + RND_HALF;
      my3_q <= $signed({1'b0, tq2}) * g2.dy + RND_HALF;

      g4_q  <= g3_q;
      px4_q <= PT_W'(g3_q.x1) + PT_W'(mx3_q >>> F);
      py4_q <= PT_W'(g3_q.y1) + PT_W'(my3_q >>> F);

      g5_q  <= g4_q;
      px5_q <= px4_q;
      py5_q <= py4_q;
      ex5_q <= EX_W'(px4_q) - EX_W'(g4_q.ax);
      ey5_q <= EX_W'(py4_q) - EX_W'(g4_q.ay);

      g6_q   <= g5_q;
      px6_q  <= px5_q;
      py6_q  <= py5_q;
      pdx6_q <= ex5_q * g5_q.abx;
      pdy6_q <= ey5_q * g5_q.aby;

      // The point must project onto the edge, both ends included.
      n7_q.hit  <= !g6_q.miss && !dp6[DP_W-1] && (dp6 <= $signed({2'b00, g6_q.ll}));
      n7_q.px   <= W'(px6_q);
      n7_q.py   <= W'(py6_q);
      n7_q.sgnx <= g6_q.aby[W];
      sgny7_q   <= !g6_q.abx[W];
      ll7_q     <= g6_q.ll;
      sqx7_q    <= g6_q.sqx;
      sqy7_q    <= g6_q.sqy;
    end
  end

  sei_div #(
    .DATA_W (DW),
    .QUO_W  (F + 1),
    .SIDE_W ($bits(geo_t))
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .num_i   (un1_q),
    .den_i   (ud1_q),
    .side_i  (g1_q),
    .valid_o (v2),
    .quo_o   (tq2),
    .side_o  (g2)
  );

  // Squared normal components over the squared length, as nx = AB.y, ny = -AB.x.
  sei_div #(
    .DATA_W (DW),
    .QUO_W  (NORM_QUO_BITS),
    .SIDE_W ($bits(nside_t))
  ) u_norm_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (DW'(sqy7_q)),
    .den_i   (ll7_q),
    .side_i  (n7_q),
    .valid_o (vd),
    .quo_o   (qx),
    .side_o  (nd)
  );

  sei_div #(
    .DATA_W (DW),
    .QUO_W  (NORM_QUO_BITS),
    .SIDE_W (1)
  ) u_norm_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (DW'(sqx7_q)),
    .den_i   (ll7_q),
    .side_i  (sgny7_q),
    .valid_o (),
    .quo_o   (qy),
    .side_o  (sgny_d)
  );

  sei_sqrt #(
    .IN_W   (NORM_QUO_BITS),
    .SIDE_W ($bits(nside_t))
  ) u_norm_sqrt_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd),
    .rad_i   (qx),
    .side_i  (nd),
    .valid_o (vs),
    .root_o  (rx),
    .side_o  (ns)
  );

  sei_sqrt #(
    .IN_W   (NORM_QUO_BITS),
    .SIDE_W (1)
  ) u_norm_sqrt_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd),
    .rad_i   (qy),
    .side_i  (sgny_d),
    .valid_o (),
    .root_o  (ry),
    .side_o  (sgny_s)
  );

  // The root carries one extra fraction bit; adding one and dropping it
  // rounds to nearest with ties away from zero.
  assign rnd_x = (NORM_ROOT_BITS + 1)'(rx) + (NORM_ROOT_BITS + 1)'(1);
  assign rnd_y = (NORM_ROOT_BITS + 1)'(ry) + (NORM_ROOT_BITS + 1)'(1);
  assign mag_x = NORM_WIDTH'(rnd_x[NORM_ROOT_BITS:1]);
  assign mag_y = NORM_WIDTH'(rnd_y[NORM_ROOT_BITS:1]);
  assign nrm_x = ns.sgnx ? -mag_x : mag_x;
  assign nrm_y = sgny_s  ? -mag_y : mag_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= ns.hit;
      cx_q  <= ns.hit ? ns.px : '0;
      cy_q  <= ns.hit ? ns.py : '0;
      nx_q  <= ns.hit ? nrm_x : '0;
      ny_q  <= ns.hit ? nrm_y : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign cross_x_o       = cx_q;
  assign cross_y_o       = cy_q;
  assign unit_normal_x_o = nx_q;
  assign unit_normal_y_o = ny_q;

endmodule

### src/segment_edge_intersection.sv
// Top level of the segment and edge intersection block with its front end.
//
//   channel  direction  handshake                 payload
//   in       into block in_valid_i / in_stall_o   segment p1, p2 and edge A, B (Q8.8)
//   out      from block out_valid_o / out_stall_i hit, crossing point (Q8.8),
//                                                 unit normal (Q2.14)
//
// One item is accepted per cycle and one result leaves per cycle when neither side stalls.
// An accepted item passes the two front stages, the queue and the back end, with its
// ratio divider (one quotient bit per stage), the two normal dividers (31 stages) and
// the square roots (16 stages). Reset clears only the valid flags and the queue pointers.
// An output stall freezes the back end; the front keeps taking items into its two stages
// and the four-entry queue, and raises in_stall_o only once the queue is full and its last stage holds an item.
module segment_edge_intersection import sei_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int unsigned RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] edge_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] edge_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] edge_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] edge_b_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o,
  output logic signed [NORM_WIDTH-1:0]  unit_normal_x_o,
  output logic signed [NORM_WIDTH-1:0]  unit_normal_y_o
);

  localparam int unsigned W       = COORD_WIDTH;
  localparam int unsigned DW      = 2 * W + 3;
  localparam int unsigned SQ_W    = 2 * W + 2;
  localparam int unsigned ENTRY_W = 12 * W + 11;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic                  miss;
    logic [DW-1:0]         un;
    logic [DW-1:0]         ud;
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    logic signed [W-1:0]   ax;
    logic signed [W-1:0]   ay;
    logic signed [W:0]     abx;
    logic signed [W:0]     aby;
    logic signed [W:0]     dx;
    logic signed [W:0]     dy;
  } entry_t;

  // Differences and the four dot product terms after the first front stage.
  typedef struct packed {
    logic signed [W-1:0]    x1;
    logic signed [W-1:0]    y1;
    logic signed [W-1:0]    ax;
    logic signed [W-1:0]    ay;
    logic signed [W:0]      abx;
    logic signed [W:0]      aby;
    logic signed [W:0]      dx;
    logic signed [W:0]      dy;
    logic signed [SQ_W-1:0] pnrx;
    logic signed [SQ_W-1:0] pnry;
    logic signed [SQ_W-1:0] pndx;
    logic signed [SQ_W-1:0] pndy;
  } front_t;

  logic          fen;
  logic          accept;
  logic          push;
  logic          pop;
  queue_status_t queue;
  logic [ENTRY_W-1:0] queue_data;

  logic signed [W:0] abx, aby, ny, rx, ry, dx, dy;
  front_t fa_d;
  logic   fa_v_q, fb_v_q;
  front_t fa_q;
  entry_t fb_q;

  logic signed [DW-1:0] num, den;
  logic [DW-1:0]        un, ud;
  logic                 miss;

  // The front moves unless its last stage holds an item the queue cannot take.
  assign fen        = !fb_v_q || !queue.full;
  assign in_stall_o = !fen;
  assign accept     = in_valid_i && fen;
  assign push       = fb_v_q && !queue.full;

  // Edge vector, normal n = (AB.y, -AB.x), and the offsets the dot products need.
  assign abx = (W + 1)'(edge_b_x_i) - (W + 1)'(edge_a_x_i);
  assign aby = (W + 1)'(edge_b_y_i) - (W + 1)'(edge_a_y_i);
  assign ny  = -abx;
  assign rx  = (W + 1)'(seg_start_x_i) - (W + 1)'(edge_a_x_i);
  assign ry  = (W + 1)'(seg_start_y_i) - (W + 1)'(edge_a_y_i);
  assign dx  = (W + 1)'(seg_end_x_i) - (W + 1)'(seg_start_x_i);
  assign dy  = (W + 1)'(seg_end_y_i) - (W + 1)'(seg_start_y_i);

  always_comb begin
    fa_d.x1   = seg_start_x_i;
    fa_d.y1   = seg_start_y_i;
    fa_d.ax   = edge_a_x_i;
    fa_d.ay   = edge_a_y_i;
    fa_d.abx  = abx;
    fa_d.aby  = aby;
    fa_d.dx   = dx;
    fa_d.dy   = dy;
    fa_d.pnrx = aby * rx;
    fa_d.pnry = ny * ry;
    fa_d.pndx = aby * dx;
    fa_d.pndy = ny * dy;
  end

  // Classification: a segment parallel to the edge, or a ratio below zero or
  // above one, is a miss. The ratio test runs on the exact dot products.
  assign num  = DW'(fa_q.pnrx) + DW'(fa_q.pnry);
  assign den  = DW'(fa_q.pndx) + DW'(fa_q.pndy);
  assign un   = num[DW-1] ? -num : num;
  assign ud   = den[DW-1] ? -den : den;
  assign miss = (den == '0) || ((num != '0) && (num[DW-1] == den[DW-1])) || (un > ud);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_v_q <= 1'b0;
      fb_v_q <= 1'b0;
    end else if (fen) begin
      fa_v_q <= accept;
      fb_v_q <= fa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      fa_q    <= fa_d;
      fb_q.miss <= miss;
      fb_q.un   <= un;
      fb_q.ud   <= ud;
      fb_q.x1   <= fa_q.x1;
      fb_q.y1   <= fa_q.y1;
      fb_q.ax   <= fa_q.ax;
      fb_q.ay   <= fa_q.ay;
      fb_q.abx  <= fa_q.abx;
      fb_q.aby  <= fa_q.aby;
      fb_q.dx   <= fa_q.dx;
      fb_q.dy   <= fa_q.dy;
    end
  end

  sei_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (fb_q),
    .pop_i    (pop),
    .data_o   (queue_data),
    .status_o (queue)
  );

  sei_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (queue_data),
    .queue_i         (queue),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .hit_o           (hit_o),
    .cross_x_o       (cross_x_o),
    .cross_y_o       (cross_y_o),
    .unit_normal_x_o (unit_normal_x_o),
    .unit_normal_y_o (unit_normal_y_o)
  );

endmodule

### tb/testbench.sv
// Testbench for the segment and edge intersection block: directed and random items.
module testbench;
  import sei_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned RF = RATIO_FRAC_BITS_DEF;
  localparam int LATENCY = RF + 59;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x1, y1, x2, y2, ax, ay, bx, by;
  } pair_t;

  typedef struct packed {
    logic hit;
    logic signed [CW-1:0] cx, cy;
    logic signed [NORM_WIDTH-1:0] nx, ny;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pair_t item = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic signed [CW-1:0] cross_x_o, cross_y_o;
  logic signed [NORM_WIDTH-1:0] unit_normal_x_o, unit_normal_y_o;

  crossing_t expected_crossings[$];
  int unsigned mismatches = 0;
  longint cycles = 0;
  bit stall_random = 1'b1;
  int unsigned hold_off = 0;   // cycles the receiver still has to hold off
  bit send_gaps = 1'b1;

  segment_edge_intersection u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .seg_start_x_i(item.x1), .seg_start_y_i(item.y1),
    .seg_end_x_i(item.x2), .seg_end_y_i(item.y2),
    .edge_a_x_i(item.ax), .edge_a_y_i(item.ay),
    .edge_b_x_i(item.bx), .edge_b_y_i(item.by),
    .out_valid_o, .out_stall_i, .hit_o, .cross_x_o, .cross_y_o,
    .unit_normal_x_o, .unit_normal_y_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Integer square root, floor.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // One component of the edge normal scaled to unit length in Q2.14, rounded
  // to nearest with ties away from zero.
  function automatic longint unit_component(longint a, longint unsigned len2);
    longint unsigned ua, a2, q, k;
    if (a == 0 || len2 == 0) return 0;
    ua = (a < 0) ? -a : a;
    a2 = ua * ua;
    q = floor_root((a2 << 28) / len2);
    k = 2 * q + 1;
    if ((a2 << 30) >= k * k * len2) q++;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // The crossing result that a segment and edge pair must produce.
  function automatic crossing_t predict_crossing(pair_t p);
    crossing_t r;
    longint abx, aby, nx, ny, dx, dy, num, den, px, py, dp, ll, half;
    longint unsigned un, ud, tq;
    r = '0;
    abx = longint'(p.bx) - p.ax;
    aby = longint'(p.by) - p.ay;
    nx = aby;
    ny = -abx;
    dx = longint'(p.x2) - p.x1;
    dy = longint'(p.y2) - p.y1;
    num = nx * (longint'(p.x1) - p.ax) + ny * (longint'(p.y1) - p.ay);
    den = nx * dx + ny * dy;
    half = longint'(1) << (RF - 1);
    // A parallel or degenerate pair misses.
    if (den == 0) return r;
    // The ratio must lie in [0,1], decided on the exact dot products.
    if (num != 0 && ((num < 0) == (den < 0))) return r;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (un > ud) return r;
    tq = (un << RF) / ud;
    // An arithmetic shift floors, so adding half rounds ties upward.
    px = longint'(p.x1) + ((longint'(tq) * dx + half) >>> RF);
    py = longint'(p.y1) + ((longint'(tq) * dy + half) >>> RF);
    dp = (px - p.ax) * abx + (py - p.ay) * aby;
    ll = abx * abx + aby * aby;
    if (dp < 0 || dp > ll) return r;
    r.hit = 1'b1;
    r.cx = px[CW-1:0];
    r.cy = py[CW-1:0];
    r.nx = NORM_WIDTH'(unit_component(nx, ll));
    r.ny = NORM_WIDTH'(unit_component(ny, ll));
    return r;
  endfunction

  // Offers one item and holds it until the block takes it.
  task automatic send_pair(pair_t p);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    item <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_crossings.insert(expected_crossings.size(), predict_crossing(p));
    @(negedge clk_i);
  endtask

  task automatic pause_sending();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(16'sh7fff);
      1: return coord_t'(16'sh8000);
      2: return coord_t'(int'($urandom_range(0, 15)) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // A segment drawn to pass through a point near the edge, so that most
  // such pairs reach the projection test and many of them hit.
  function automatic pair_t crossing_pair(int span);
    pair_t p;
    int t, sx, sy, ex, ey, mx, my;
    p.ax = coord_t'($urandom_range(0, 2 * span) - span);
    p.ay = coord_t'($urandom_range(0, 2 * span) - span);
    p.bx = coord_t'($urandom_range(0, 2 * span) - span);
    p.by = coord_t'($urandom_range(0, 2 * span) - span);
    t = $urandom_range(0, 1100) - 50;
    mx = p.ax + (int'(p.bx) - p.ax) * t / 1000;
    my = p.ay + (int'(p.by) - p.ay) * t / 1000;
    sx = $urandom_range(0, 2 * span) - span;
    sy = $urandom_range(0, 2 * span) - span;
    ex = 2 * mx - sx + $urandom_range(0, 6) - 3;
    ey = 2 * my - sy + $urandom_range(0, 6) - 3;
    p.x1 = coord_t'(sx);
    p.y1 = coord_t'(sy);
    p.x2 = coord_t'(ex);
    p.y2 = coord_t'(ey);
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    case ($urandom_range(0, 9))
      0: p = {any_coord(), any_coord(), any_coord(), any_coord(),
              any_coord(), any_coord(), any_coord(), any_coord()};
      1: p = pair_t'({$urandom, $urandom, $urandom, $urandom});
      2: p = crossing_pair(32767);
      default: p = crossing_pair(($urandom_range(0, 1) != 0) ? 4000 : 400);
    endcase
    return p;
  endfunction

  // Directed corners: extremes, parallel and degenerate pairs, ratio ends,
  // projection ends and ties.
  task automatic test_directed();
    pair_t p;
    send_pair('0);
    send_pair('1);
    send_pair({8{coord_t'(16'sh7fff)}});
    send_pair({8{coord_t'(16'sh8000)}});
    // Plain crossing of a vertical segment over a horizontal edge.
    send_pair({16'sh0000, -16'sh0100, 16'sh0000, 16'sh0100,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    // Segment starts on the edge (ratio zero) and ends on it (ratio one).
    send_pair({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0100,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    send_pair({16'sh0000, -16'sh0100, 16'sh0000, 16'sh0000,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    // Segment stops short of the edge, and starts past it.
    send_pair({16'sh0000, -16'sh0200, 16'sh0000, -16'sh0100,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    send_pair({16'sh0000, 16'sh0100, 16'sh0000, 16'sh0200,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    // Parallel segment lying on the edge, and a zero-length edge.
    send_pair({-16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    send_pair({16'sh0000, -16'sh0100, 16'sh0000, 16'sh0100,
               16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    // Crossing exactly at either edge vertex, then just outside.
    send_pair({16'sh0200, -16'sh0100, 16'sh0200, 16'sh0100,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    send_pair({-16'sh0200, -16'sh0100, -16'sh0200, 16'sh0100,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    send_pair({16'sh0201, -16'sh0100, 16'sh0201, 16'sh0100,
               -16'sh0200, 16'sh0000, 16'sh0200, 16'sh0000});
    // Diagonal edge with an odd ratio, exercising rounding ties.
    send_pair({16'sh0001, -16'sh0003, 16'sh0002, 16'sh0004,
               -16'sh0005, -16'sh0005, 16'sh0007, 16'sh0007});
    send_pair({16'sh0000, -16'sh0001, 16'sh0001, 16'sh0002,
               -16'sh0003, 16'sh0000, 16'sh0003, 16'sh0000});
    // Full-range edge and segment.
    send_pair({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
               16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    send_pair({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
               16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    repeat (6) begin
      p = crossing_pair(32767);
      send_pair(p);
    end
  endtask

  // Random pairs with random gaps and stalls on both sides.
  task automatic test_random(int unsigned count);
    repeat (count) send_pair(random_pair());
  endtask

  // Receiver holds off while the sender keeps offering items, filling the
  // block until it stalls its input.
  task automatic test_back_pressure();
    send_gaps = 1'b0;
    hold_off = 3 * LATENCY;
    repeat (2 * LATENCY) send_pair(random_pair());
    send_gaps = 1'b1;
  endtask

  // Sender pauses until every expected result has arrived, then sends more items.
  task automatic test_drain_pause();
    pause_sending();
    while (expected_crossings.size() != 0) @(negedge clk_i);
    repeat (50) send_pair(random_pair());
  endtask

  // Last part of the run with no idling on either side.
  task automatic test_full_rate();
    stall_random = 1'b0;
    send_gaps = 1'b0;
    repeat (300) send_pair(random_pair());
    pause_sending();
  endtask

  // Receiver stall: random bursts, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (stall_random) begin
      out_stall_i <= ($urandom_range(0, 9) < 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_crossings.size() == 0) begin
        $display("%0t: result with none expected: hit %0b x %0d y %0d nx %0d ny %0d",
                 $time, hit_o, cross_x_o, cross_y_o, unit_normal_x_o, unit_normal_y_o);
        mismatches++;
      end else begin
        want = expected_crossings.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
          mismatches++;
        end
        if (cross_x_o !== want.cx) begin
          $display("%0t: cross_x expected %0d actual %0d", $time, want.cx, cross_x_o);
          mismatches++;
        end
        if (cross_y_o !== want.cy) begin
          $display("%0t: cross_y expected %0d actual %0d", $time, want.cy, cross_y_o);
          mismatches++;
        end
        if (unit_normal_x_o !== want.nx) begin
          $display("%0t: unit_normal_x expected %0d actual %0d",
                   $time, want.nx, unit_normal_x_o);
          mismatches++;
        end
        if (unit_normal_y_o !== want.ny) begin
          $display("%0t: unit_normal_y expected %0d actual %0d",
                   $time, want.ny, unit_normal_y_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(800);
    test_back_pressure();
    test_drain_pause();
    test_random(800);
    test_full_rate();
    while (expected_crossings.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### segment_edge_intersection.f
src/sei_pkg.sv
src/sei_fifo.sv
src/sei_div.sv
src/sei_sqrt.sv
src/sei_back.sv
src/segment_edge_intersection.sv
tb/testbench.sv
